>>> rtl/core/rc4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants, operation codes and word types for the rc4 cipher core.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int KEY_DEPTH = 256;
  localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int PERM_SIZE = 256;
  localparam int PERM_AW   = 8;
  localparam int LEN_W     = 9;

  localparam logic [LEN_W-1:0] KEY_LENGTH_RESET = 9'd16;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SCHED = 2'd1;
  localparam logic [1:0] OP_ENC   = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] key_index;
    logic [7:0] key_byte;
    logic [7:0] data_byte;
    logic       last_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       last_out;
  } out_word_t;

endpackage
`default_nettype wire

>>> rtl/core/rc4_key_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_key_mem
// Key byte store: one write port for key loads, one registered read port.
// Loads beyond the store depth are dropped.
// ----------------------------------------------------------------------------
module rc4_key_mem (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [7:0]                wr_index,
  input  wire logic [7:0]                wr_data,
  input  wire logic [rc4_pkg::KEY_AW-1:0] rd_index,
  output logic      [7:0]                rd_data
);
  import rc4_pkg::*;

  localparam logic [8:0] DEPTH_LIMIT = 9'(KEY_DEPTH);

  logic [7:0] key_mem [KEY_DEPTH];
  logic       wr_ok;

  assign wr_ok = wr_en && ({1'b0, wr_index} < DEPTH_LIMIT);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      key_mem[wr_index[KEY_AW-1:0]] <= wr_data;
    end
    rd_data <= key_mem[rd_index];
  end

endmodule
`default_nettype wire

>>> rtl/core/rc4_stream_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 stream cipher core: key store, key schedule and keystream generator
// around a 256 x 8 permutation memory with registered read data.
//
//   port group     direction  handshake           word
//   in_*           in         in_valid/in_stall   in_word_t
//   out_*          out        out_valid/out_stall out_word_t
//   cfg_*          in         cfg_wr_en           key_length (9 bits)
//
// key load: a single write into the key store. encrypt steps are set by the
// single read and single write port of the permutation memory (read s[i],
// read s[j], write s[i] with keystream read, write s[j]).
// key schedule: fill 256 entries, then per entry read s[i], read s[j], swap.
// rst is synchronous, clears control state and indices, sets key_length to 16.
// a waiting result does not block acceptance; the last encrypt step holds
// while the output register is full and stalled.
// ----------------------------------------------------------------------------
module rc4_stream_cipher (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rc4_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rc4_pkg::out_word_t      out_word,
  input  wire logic               cfg_wr_en,
  input  wire logic [8:0]         cfg_wr_data
);
  import rc4_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_FILL = 4'd1;
  localparam logic [3:0] ST_KRD  = 4'd2;
  localparam logic [3:0] ST_KJ   = 4'd3;
  localparam logic [3:0] ST_KW1  = 4'd4;
  localparam logic [3:0] ST_KW2  = 4'd5;
  localparam logic [3:0] ST_E1   = 4'd6;
  localparam logic [3:0] ST_E2   = 4'd7;
  localparam logic [3:0] ST_E3   = 4'd8;

  localparam logic [LEN_W-1:0]   DEPTH_LEN = LEN_W'(KEY_DEPTH);
  localparam logic [PERM_AW-1:0] X_LAST    = PERM_AW'(PERM_SIZE - 1);

  logic [3:0]         state;
  logic [3:0]         state_next;
  logic [LEN_W-1:0]   key_length;
  logic [7:0]         index_i;
  logic [7:0]         index_j;
  logic [PERM_AW-1:0] x;
  logic [KEY_AW-1:0]  k;
  logic [KEY_AW-1:0]  k_last;
  logic [7:0]         a_val;
  logic [7:0]         b_val;
  logic [7:0]         t_idx;
  logic [7:0]         data_r;
  logic               last_r;

  logic [7:0]         perm_mem [PERM_SIZE];
  logic [7:0]         prdata;
  logic [7:0]         praddr;
  logic               pwe;
  logic [7:0]         pwaddr;
  logic [7:0]         pwdata;
  logic [7:0]         kdata;

  logic               in_acc;
  logic               out_free;
  logic [LEN_W-1:0]   len_eff;
  logic [LEN_W-1:0]   len_m1;
  logic [7:0]         i_inc;
  logic [7:0]         ks_byte;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign i_inc    = index_i + 8'd1;

  always_comb begin
    if (key_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (key_length > DEPTH_LEN) begin
      len_eff = DEPTH_LEN;
    end else begin
      len_eff = key_length;
    end
    len_m1 = len_eff - LEN_W'(1);
  end

  // forward pending swap writes into the keystream lookup
  always_comb begin
    if (t_idx == index_j) begin
      ks_byte = a_val;
    end else if (t_idx == index_i) begin
      ks_byte = b_val;
    end else begin
      ks_byte = prdata;
    end
  end

  rc4_key_mem u_key_mem (
    .clk      (clk),
    .wr_en    (in_acc && (in_word.operation == OP_LOAD)),
    .wr_index (in_word.key_index),
    .wr_data  (in_word.key_byte),
    .rd_index (k),
    .rd_data  (kdata)
  );

  always_comb begin
    state_next = state;
    praddr     = t_idx;
    pwe        = 1'b0;
    pwaddr     = x;
    pwdata     = x;
    case (state)
      ST_IDLE: begin
        praddr = i_inc;
        if (in_acc) begin
          case (in_word.operation)
            OP_SCHED: state_next = ST_FILL;
            OP_ENC:   state_next = ST_E1;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        pwe = 1'b1;
        if (x == X_LAST) begin
          state_next = ST_KRD;
        end
      end
      ST_KRD: begin
        praddr     = x;
        state_next = ST_KJ;
      end
      ST_KJ: begin
        praddr     = index_j + prdata + kdata;
        state_next = ST_KW1;
      end
      ST_KW1: begin
        pwe        = 1'b1;
        pwaddr     = x;
        pwdata     = prdata;
        state_next = ST_KW2;
      end
      ST_KW2: begin
        pwe        = 1'b1;
        pwaddr     = index_j;
        pwdata     = a_val;
        state_next = (x == X_LAST) ? ST_IDLE : ST_KRD;
      end
      ST_E1: begin
        praddr     = index_j + prdata;
        state_next = ST_E2;
      end
      ST_E2: begin
        pwe        = 1'b1;
        pwaddr     = index_i;
        pwdata     = prdata;
        praddr     = a_val + prdata;
        state_next = ST_E3;
      end
      ST_E3: begin
        pwe    = 1'b1;
        pwaddr = index_j;
        pwdata = a_val;
        praddr = t_idx;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pwe) begin
      perm_mem[pwaddr] <= pwdata;
    end
    prdata <= perm_mem[praddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      key_length <= KEY_LENGTH_RESET;
      index_i    <= '0;
      index_j    <= '0;
      out_valid  <= 1'b0;
      x          <= '0;
      k          <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        key_length <= cfg_wr_data;
      end
      if ((state == ST_E3) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc && (in_word.operation == OP_SCHED)) begin
            x       <= '0;
            k       <= '0;
            index_j <= '0;
            k_last  <= len_m1[KEY_AW-1:0];
          end
          if (in_acc && (in_word.operation == OP_ENC)) begin
            index_i <= i_inc;
            data_r  <= in_word.data_byte;
            last_r  <= in_word.last_in;
          end
        end
        ST_FILL: x <= x + PERM_AW'(1);
        ST_KJ: begin
          a_val   <= prdata;
          index_j <= index_j + prdata + kdata;
        end
        ST_KW2: begin
          x <= x + PERM_AW'(1);
          k <= (k == k_last) ? '0 : k + KEY_AW'(1);
          if (x == X_LAST) begin
            index_i <= '0;
            index_j <= '0;
          end
        end
        ST_E1: begin
          a_val   <= prdata;
          index_j <= index_j + prdata;
        end
        ST_E2: begin
          b_val <= prdata;
          t_idx <= a_val + prdata;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_E3) && out_free) begin
      out_word.cipher_byte <= data_r ^ ks_byte;
      out_word.last_out    <= last_r;
    end
  end

endmodule
`default_nettype wire
